// ===== rtl/b62_pkg.sv =====
// shared constants, types and functions for the base-62 text encoder
`default_nettype none

package b62_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned StepBits    = 8;
  localparam int unsigned CHUNKS      = (VALUE_WIDTH + StepBits - 1) / StepBits;
  localparam int unsigned PAD_W       = CHUNKS * StepBits;
  localparam int unsigned CNT_W       = $clog2(CHUNKS + 1);
  // 62 > 2^5, so a magnitude of VALUE_WIDTH bits never needs more digits than this
  localparam int unsigned ND_MAX      = (VALUE_WIDTH + 4) / 5;
  localparam int unsigned DIG_IDX_W   = $clog2(ND_MAX);
  localparam int unsigned NDIG_W      = $clog2(ND_MAX + 1);
  localparam logic [5:0]  RADIX       = 6'd62;
  localparam logic [6:0]  MINUS_CHAR  = 7'h2D;
  localparam logic [7:0]  BUF_LEN_RST = 8'd16;

  typedef struct packed {
    logic [StepBits-1:0] quo;
    logic [5:0]          rem;
  } step_t;

  typedef struct packed {
    logic       done;
    logic [5:0] rem;
  } div_status_t;

  // one byte of long division by 62: restoring, one quotient bit per step
  function automatic step_t div62_step(input logic [5:0] rem_in,
                                       input logic [StepBits-1:0] chunk);
    step_t      res;
    logic [6:0] r;
    r = {1'b0, rem_in};
    res.quo = '0;
    for (int i = StepBits - 1; i >= 0; i--) begin
      r = {r[5:0], chunk[i]};
      if (r >= {1'b0, RADIX}) begin
        r = r - {1'b0, RADIX};
        res.quo[i] = 1'b1;
      end
    end
    res.rem = r[5:0];
    return res;
  endfunction

  // digit 0..61 to '0'-'9', 'a'-'z', 'A'-'Z'
  function automatic logic [6:0] b62_char(input logic [5:0] d);
    logic [6:0] c;
    if (d < 6'd10) begin
      c = 7'h30 + {1'b0, d};
    end else if (d < 6'd36) begin
      c = 7'h61 + {1'b0, d - 6'd10};
    end else if (d < 6'd62) begin
      c = 7'h41 + {1'b0, d - 6'd36};
    end else begin
      c = '0;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/b62_divider.sv =====
// iterative divide-by-62 unit, one byte of the dividend per cycle
`default_nettype none

module b62_divider (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [b62_pkg::PAD_W-1:0]    operand_i,
  output      logic [b62_pkg::PAD_W-1:0]    quotient_o,
  output      b62_pkg::div_status_t         status_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [b62_pkg::CNT_W-1:0]     cnt_q;
  logic [b62_pkg::PAD_W-1:0]     work_q;
  logic [5:0]                    rem_q;
  b62_pkg::step_t                step;

  // dividend bytes shift out the top while quotient bytes shift in below
  assign step = b62_pkg::div62_step(rem_q,
                                    work_q[b62_pkg::PAD_W-1 -: b62_pkg::StepBits]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == b62_pkg::CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= b62_pkg::CNT_W'(b62_pkg::CHUNKS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == b62_pkg::CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= operand_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      work_q <= (work_q << b62_pkg::StepBits) | b62_pkg::PAD_W'(step.quo);
      rem_q  <= step.rem;
    end
  end

  assign quotient_o    = work_q;
  assign status_o.done = done_q;
  assign status_o.rem  = rem_q;

endmodule

`default_nettype wire

// ===== rtl/signed_int_to_base62_text.sv =====
// top level: signed integer to base-62 text encoder
//
// s_axis carries one signed value per transfer (tdata, value in the low bits).
// m_axis returns the text one character per transfer, most significant first,
// a leading '-' for negative values; tlast marks the final character.
// If the characters plus a terminator exceed buffer_length, a single transfer
// with tdata = 0, tuser = 1 and tlast = 1 replaces the text.
// buffer_length is written through cfg_we_i / cfg_wdata_i; reset 16. The user
// must write it only while idle; the block itself does not enforce this.
// One value at a time: s_axis_tready is high only while the sequencer is idle.
// Each digit takes the shared divide-by-62 unit through 4 byte steps, then one
// step to store the digit and, while the quotient is nonzero, restart the unit on
// it. A length check follows the last digit, then one character per cycle goes
// out as m_axis takes it. A stalled receiver holds the output register; the
// sequencer waits with it. The last character may sit in the output register
// while the next value is accepted. Reset empties the output register and
// returns to idle.
`default_nettype none

module signed_int_to_base62_text (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [7:0]                 cfg_wdata_i,
  input  wire logic                       s_axis_tvalid,
  output      logic                       s_axis_tready,
  // value
  input  wire logic [b62_pkg::PAD_W-1:0]  s_axis_tdata,
  output      logic                       m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // text_char [6:0], zero [7]
  output      logic [7:0]                 m_axis_tdata,
  output      logic                       m_axis_tlast,
  // too_long
  output      logic                       m_axis_tuser
);

  typedef enum logic [1:0] {
    StIdle,
    StDivide,
    StCheck,
    StEmit
  } state_e;

  state_e                           state_q;
  logic [7:0]                       buf_len_q;
  logic                             neg_q;
  logic                             err_q;
  logic                             sign_pend_q;
  logic [b62_pkg::NDIG_W-1:0]       ndig_q;
  logic [b62_pkg::DIG_IDX_W-1:0]    idx_q;
  logic [5:0]                       digits_q [b62_pkg::ND_MAX];
  logic                             m_valid_q;
  logic [6:0]                       m_char_q;
  logic                             m_last_q;
  logic                             m_err_q;

  logic                                in_accept;
  logic [b62_pkg::VALUE_WIDTH-1:0]     raw;
  logic [b62_pkg::VALUE_WIDTH-1:0]     mag;
  logic                                div_start;
  logic [b62_pkg::PAD_W-1:0]           div_operand;
  logic [b62_pkg::PAD_W-1:0]           quotient;
  b62_pkg::div_status_t                div_status;
  logic                                quo_zero;
  logic                                slot_free;
  logic                                out_load;
  logic [8:0]                          need_len;

  assign s_axis_tready = (state_q == StIdle);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign raw = s_axis_tdata[b62_pkg::VALUE_WIDTH-1:0];
  // most negative value wraps to 2^(W-1), its true magnitude as unsigned
  assign mag = raw[b62_pkg::VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;

  assign quo_zero    = (quotient == '0);
  assign div_start   = in_accept ||
                       ((state_q == StDivide) && div_status.done && !quo_zero);
  assign div_operand = in_accept ? b62_pkg::PAD_W'(mag) : quotient;

  assign slot_free = !m_valid_q || m_axis_tready;
  assign out_load  = (state_q == StEmit) && slot_free;
  assign need_len  = 9'(ndig_q) + 9'(neg_q) + 9'd1;

  b62_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .operand_i  (div_operand),
    .quotient_o (quotient),
    .status_o   (div_status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      buf_len_q   <= b62_pkg::BUF_LEN_RST;
      neg_q       <= 1'b0;
      err_q       <= 1'b0;
      sign_pend_q <= 1'b0;
      ndig_q      <= '0;
      idx_q       <= '0;
      m_valid_q   <= 1'b0;
      m_char_q    <= '0;
      m_last_q    <= 1'b0;
      m_err_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        buf_len_q <= cfg_wdata_i;
      end
      if (m_valid_q && m_axis_tready && !out_load) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_accept) begin
            neg_q   <= raw[b62_pkg::VALUE_WIDTH-1];
            ndig_q  <= '0;
            state_q <= StDivide;
          end
        end
        StDivide: begin
          if (div_status.done) begin
            ndig_q <= ndig_q + 1'b1;
            if (quo_zero) begin
              state_q <= StCheck;
            end
          end
        end
        StCheck: begin
          err_q       <= (need_len > {1'b0, buf_len_q});
          sign_pend_q <= neg_q;
          idx_q       <= b62_pkg::DIG_IDX_W'(ndig_q - 1'b1);
          state_q     <= StEmit;
        end
        StEmit: begin
          if (slot_free) begin
            m_valid_q <= 1'b1;
            if (err_q) begin
              m_char_q <= '0;
              m_last_q <= 1'b1;
              m_err_q  <= 1'b1;
              state_q  <= StIdle;
            end else if (sign_pend_q) begin
              m_char_q    <= b62_pkg::MINUS_CHAR;
              m_last_q    <= 1'b0;
              m_err_q     <= 1'b0;
              sign_pend_q <= 1'b0;
            end else begin
              m_char_q <= b62_pkg::b62_char(digits_q[idx_q]);
              m_last_q <= (idx_q == '0);
              m_err_q  <= 1'b0;
              if (idx_q == '0) begin
                state_q <= StIdle;
              end else begin
                idx_q <= idx_q - 1'b1;
              end
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // digit store, least significant digit at index 0
  always_ff @(posedge clk_i) begin
    if ((state_q == StDivide) && div_status.done) begin
      digits_q[ndig_q[b62_pkg::DIG_IDX_W-1:0]] <= div_status.rem;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_char_q};
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_err_q;

  // a non-final character is only pending while the sequencer is still emitting
  a_mid_text_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (state_q == StEmit))
    else $error("non-final character outstanding outside emit state");

  // the error result is alone: it always ends the item and carries no character
  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata == 8'h00)))
    else $error("error result not final or not zero");

  // divider results arrive only while the sequencer collects digits
  a_div_done_in_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_status.done |-> (state_q == StDivide))
    else $error("divider finished outside divide state");

  // digit count is nonzero and never exceeds the digit store
  a_ndig_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StCheck) || (state_q == StEmit)) |->
      ((ndig_q != '0) && (ndig_q <= b62_pkg::NDIG_W'(b62_pkg::ND_MAX))))
    else $error("digit count out of range");

endmodule

`default_nettype wire
